/* hw/rtl/vba_pkg.sv */
`default_nettype none

package vba_pkg;

    localparam int INDEX_W            = 10;
    localparam int VERSION_W          = 8;
    localparam int OFFSET_W           = 12;
    localparam int COUNT_W            = 13;
    localparam int SPAN_W             = COUNT_W + 1;
    localparam int BLOCK_BYTES        = 4096;
    localparam int NUM_BLOCKS_DEFAULT = 1024;
    localparam int NUM_BLOCKS_W       = 17;

    typedef enum logic [1:0] {
        OP_ALLOC = 2'd0,
        OP_FREE  = 2'd1,
        OP_READ  = 2'd2,
        OP_WRITE = 2'd3
    } op_t;

    typedef struct packed {
        op_t                  operation;
        logic [INDEX_W-1:0]   block_index;
        logic [VERSION_W-1:0] expected_version;
        logic [OFFSET_W-1:0]  byte_offset;
        logic [COUNT_W-1:0]   byte_count;
    } req_t;

    typedef struct packed {
        logic                 granted;
        logic [INDEX_W-1:0]   allocated_index;
        logic [VERSION_W-1:0] allocated_version;
    } rsp_t;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_READ,
        ST_SCAN
    } state_t;

    typedef struct packed {
        logic load_req;
        logic clr_wr;
        logic rd_en;
        logic commit;
    } cmd_t;

    typedef struct packed {
        logic is_alloc;
        logic hit;
        logic rd_last;
        logic addr_last;
        logic out_free;
    } status_t;

endpackage

`default_nettype wire

/* hw/rtl/versioned_block_allocator_top.sv */
// Channel  Ports                       Payload          Direction
// request  s_valid, s_ready, s_item    vba_pkg::req_t   in
// result   m_valid, m_ready, m_item    vba_pkg::rsp_t   out
//
// After reset a clearing pass writes every tag to zero, one block per cycle;
// no request is taken during that time.
// Free, read check and write check read the tag in ST_READ and register the result
// in ST_SCAN once the output register is free; the controller then returns to ST_IDLE.
// Allocate reads the tags of blocks 1 upward through the single tag memory read port until
// a free block is found or the last block is read, at most NUM_BLOCKS - 1 tags in all.
// A result beat waits in the output register; the next request is taken meanwhile,
// and its result stalls until that beat leaves.
`default_nettype none

module versioned_block_allocator_top #(
    parameter int NUM_BLOCKS = vba_pkg::NUM_BLOCKS_DEFAULT
) (
    input  wire logic           aclk,
    input  wire logic           aresetn,
    input  wire logic           s_valid,
    output logic                s_ready,
    input  wire vba_pkg::req_t  s_item,
    output logic                m_valid,
    input  wire logic           m_ready,
    output vba_pkg::rsp_t       m_item
);

    vba_pkg::cmd_t    cmd;
    vba_pkg::status_t status;

    vba_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .status  (status),
        .cmd     (cmd)
    );

    vba_datapath #(
        .NUM_BLOCKS (NUM_BLOCKS)
    ) u_datapath (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_item  (s_item),
        .m_ready (m_ready),
        .m_valid (m_valid),
        .m_item  (m_item),
        .cmd     (cmd),
        .status  (status)
    );

`ifndef ASSERT_OFF
    // Only one request is in flight at a time.
    a_one_in_flight: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("request accepted while another is in flight");

    // The tag table is being cleared right after reset.
    a_clear_after_reset: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(aresetn) |-> !s_ready)
        else $error("request taken during the clearing pass");

    // A block handed out always comes with a grant and an odd version.
    a_alloc_result: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_item.allocated_index != '0)
            |-> m_item.granted && m_item.allocated_version[0])
        else $error("allocation result is inconsistent");
`endif

endmodule

`default_nettype wire

/* hw/rtl/vba_datapath.sv */
`default_nettype none

module vba_datapath #(
    parameter int NUM_BLOCKS = vba_pkg::NUM_BLOCKS_DEFAULT
) (
    input  wire logic           aclk,
    input  wire logic           aresetn,
    input  wire vba_pkg::req_t  s_item,
    input  wire logic           m_ready,
    output logic                m_valid,
    output vba_pkg::rsp_t       m_item,
    input  wire vba_pkg::cmd_t  cmd,
    output vba_pkg::status_t    status
);

    localparam int IDX_W = $clog2(NUM_BLOCKS);
    localparam int NUM_W = vba_pkg::NUM_BLOCKS_W;
    localparam int SPN_W = vba_pkg::SPAN_W;
    localparam int VER_W = vba_pkg::VERSION_W;
    localparam logic [IDX_W-1:0] LAST_ADDR   = IDX_W'(NUM_BLOCKS - 1);
    localparam logic [NUM_W-1:0] NUM_BLOCKS_V = NUM_W'(NUM_BLOCKS);
    localparam logic [SPN_W-1:0] BLOCK_BYTES_V = SPN_W'(vba_pkg::BLOCK_BYTES);

    logic [VER_W-1:0] tag_mem [NUM_BLOCKS];

    logic [IDX_W-1:0]    addr_reg, addr_next;
    logic                m_valid_reg, m_valid_next;
    logic [IDX_W-1:0]    rd_addr_reg;
    logic [VER_W-1:0]    rd_data_reg;
    vba_pkg::op_t        op_reg;
    logic [VER_W-1:0]    ver_reg;
    logic                in_range_reg;
    logic                span_ok_reg;
    vba_pkg::rsp_t       rsp_reg, rsp_next;

    logic [NUM_W-1:0]    idx_wide;
    logic                in_range;
    logic [SPN_W-1:0]    span_sum;
    logic                span_ok;
    logic [IDX_W-1:0]    start_addr;
    logic [IDX_W-1:0]    addr_adv;
    logic [VER_W-1:0]    tag_inc;
    logic                grant;
    logic                bump;
    logic                wr_en;
    logic [IDX_W-1:0]    wr_addr;
    logic [VER_W-1:0]    wr_data;

    assign idx_wide = NUM_W'(s_item.block_index);
    assign in_range = (s_item.block_index != '0) && (idx_wide < NUM_BLOCKS_V);
    assign span_sum = SPN_W'(s_item.byte_offset) + SPN_W'(s_item.byte_count);
    assign span_ok  = (span_sum <= BLOCK_BYTES_V);

    always_comb begin
        if (s_item.operation == vba_pkg::OP_ALLOC) begin
            start_addr = IDX_W'(1);
        end else if (in_range) begin
            start_addr = idx_wide[IDX_W-1:0];
        end else begin
            start_addr = '0;
        end
    end

    assign addr_adv = (addr_reg == LAST_ADDR) ? addr_reg : addr_reg + IDX_W'(1);
    assign tag_inc  = rd_data_reg + VER_W'(1);

    always_comb begin
        case (op_reg)
            vba_pkg::OP_ALLOC: grant = !rd_data_reg[0];
            vba_pkg::OP_FREE:  grant = in_range_reg && rd_data_reg[0];
            vba_pkg::OP_READ:  grant = in_range_reg && rd_data_reg[0] && span_ok_reg
                                       && (rd_data_reg == ver_reg);
            vba_pkg::OP_WRITE: grant = in_range_reg && rd_data_reg[0] && span_ok_reg;
            default:           grant = 1'b0;
        endcase
    end

    assign bump    = grant && (op_reg inside {vba_pkg::OP_ALLOC, vba_pkg::OP_FREE});
    assign wr_en   = cmd.clr_wr || (cmd.commit && bump);
    assign wr_addr = cmd.clr_wr ? addr_reg : rd_addr_reg;
    assign wr_data = cmd.clr_wr ? '0 : tag_inc;

    always_comb begin
        rsp_next.granted           = grant;
        rsp_next.allocated_index   = '0;
        rsp_next.allocated_version = '0;
        if (grant && (op_reg == vba_pkg::OP_ALLOC)) begin
            rsp_next.allocated_index   = vba_pkg::INDEX_W'(rd_addr_reg);
            rsp_next.allocated_version = tag_inc;
        end
    end

    always_comb begin
        addr_next = addr_reg;
        if (cmd.load_req) begin
            addr_next = start_addr;
        end else if (cmd.clr_wr || cmd.rd_en) begin
            addr_next = addr_adv;
        end
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        if (cmd.commit) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            addr_reg    <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            addr_reg    <= addr_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_req) begin
            op_reg       <= s_item.operation;
            ver_reg      <= s_item.expected_version;
            in_range_reg <= in_range;
            span_ok_reg  <= span_ok;
        end
        if (cmd.commit) begin
            rsp_reg <= rsp_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            tag_mem[wr_addr] <= wr_data;
        end
        if (cmd.rd_en) begin
            rd_data_reg <= tag_mem[addr_reg];
            rd_addr_reg <= addr_reg;
        end
    end

    assign status.is_alloc  = (op_reg == vba_pkg::OP_ALLOC);
    assign status.hit       = !rd_data_reg[0];
    assign status.rd_last   = (rd_addr_reg == LAST_ADDR);
    assign status.addr_last = (addr_reg == LAST_ADDR);
    assign status.out_free  = !m_valid_reg || m_ready;

    assign m_valid = m_valid_reg;
    assign m_item  = rsp_reg;

endmodule

`default_nettype wire

/* hw/rtl/vba_ctrl.sv */
`default_nettype none

module vba_ctrl (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              s_valid,
    output logic                   s_ready,
    input  wire vba_pkg::status_t  status,
    output vba_pkg::cmd_t          cmd
);

    vba_pkg::state_t state_reg, state_next;
    logic            done;

    assign done = !status.is_alloc || status.hit || status.rd_last;

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            vba_pkg::ST_CLEAR: begin
                if (status.addr_last) begin
                    state_next = vba_pkg::ST_IDLE;
                end
            end
            vba_pkg::ST_IDLE: begin
                if (s_valid) begin
                    state_next = vba_pkg::ST_READ;
                end
            end
            vba_pkg::ST_READ: begin
                state_next = vba_pkg::ST_SCAN;
            end
            vba_pkg::ST_SCAN: begin
                if (done && status.out_free) begin
                    state_next = vba_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = vba_pkg::ST_CLEAR;
            end
        endcase
    end

    always_comb begin
        s_ready      = 1'b0;
        cmd.load_req = 1'b0;
        cmd.clr_wr   = 1'b0;
        cmd.rd_en    = 1'b0;
        cmd.commit   = 1'b0;
        case (state_reg)
            vba_pkg::ST_CLEAR: begin
                cmd.clr_wr = 1'b1;
            end
            vba_pkg::ST_IDLE: begin
                s_ready      = 1'b1;
                cmd.load_req = s_valid;
            end
            vba_pkg::ST_READ: begin
                cmd.rd_en = 1'b1;
            end
            vba_pkg::ST_SCAN: begin
                cmd.rd_en  = !done;
                cmd.commit = done && status.out_free;
            end
            default: begin
                cmd.clr_wr = 1'b0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= vba_pkg::ST_CLEAR;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

`default_nettype wire
